// ===== rtl/core/bpwl_pkg.sv =====
// Package for the backpressure wait list: widths, opcodes, status and register codes.
// Also holds the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package bpwl_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int CONN_BITS_DEF  = 16;
	localparam int TIME_BITS_DEF  = 48;

	localparam int OP_W       = 3;
	localparam int BUF_W      = 32;
	localparam int CAP_W      = 5;
	localparam int STATUS_W   = 2;
	localparam int WAIT_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MAXW_W     = 5;
	localparam int TMO_W      = 32;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_ADD    = 3'd0;
	localparam op_t OP_REMOVE = 3'd1;
	localparam op_t OP_RESUME = 3'd2;
	localparam op_t OP_EXPIRE = 3'd3;
	localparam op_t OP_MARK   = 3'd4;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_DONE = 2'd0;
	localparam status_t ST_DUP  = 2'd1;
	localparam status_t ST_FULL = 2'd2;
	localparam status_t ST_NONE = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MAX_WAITING  = 2'd0;
	localparam cfg_idx_t CFG_WAIT_TIMEOUT = 2'd1;
	localparam cfg_idx_t CFG_BUF_FLOOR    = 2'd2;

	localparam logic [MAXW_W-1:0] MAX_WAITING_RST = 5'd16;
	localparam int ZERO_MIN_THR = 2;

	typedef struct packed {
		logic    load;
		logic    idx_inc;
		logic    insert;
		logic    drop;
		logic    mark;
		logic    n_inc;
		logic    set_resp;
		logic    take_conn;
		status_t resp_status;
		logic    emit;
		logic    emit_last;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_end;
		logic hit;
		logic full;
		logic list_empty;
		logic below_thr;
		logic exp_off;
		logic expired;
		logic n_zero;
		logic n_at_cap;
		logic head_closing;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpwl_intf.sv =====
// Channel interfaces of the wait list: request, response and configuration write.
// Depends on bpwl_pkg for field widths.
`default_nettype none

interface bpwl_req_if #(
	parameter int CONN_BITS = bpwl_pkg::CONN_BITS_DEF,
	parameter int TIME_BITS = bpwl_pkg::TIME_BITS_DEF
) ();
	import bpwl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      opcode;
	logic [CONN_BITS-1:0] conn_id;
	logic [TIME_BITS-1:0] now_ms;
	logic [BUF_W-1:0]     free_buffers;
	logic [CAP_W-1:0]     expire_cap;
	modport source (output valid, opcode, conn_id, now_ms, free_buffers, expire_cap,
		input ready);
	modport sink (input valid, opcode, conn_id, now_ms, free_buffers, expire_cap,
		output ready);
endinterface

interface bpwl_rsp_if #(
	parameter int CONN_BITS = bpwl_pkg::CONN_BITS_DEF
) ();
	import bpwl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [CONN_BITS-1:0] result_conn;
	logic [WAIT_W-1:0]    waiting_after;
	logic                 last;
	modport source (output valid, status, result_conn, waiting_after, last, input ready);
	modport sink (input valid, status, result_conn, waiting_after, last, output ready);
endinterface

interface bpwl_cfg_if ();
	import bpwl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bpwl_ctrl.sv =====
// Wait list controller: one-hot state machine sequencing scans, drops and responses.
// Depends on bpwl_pkg for cmd_t, sts_t and codes.
`default_nettype none

module bpwl_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  bpwl_pkg::sts_t  sts,
	output bpwl_pkg::cmd_t  cmd
);
	import bpwl_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SCAN     = 6'b000100,
		S_RES_LOOP = 6'b001000,
		S_EXP_SCAN = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.op) inside
					OP_ADD, OP_REMOVE, OP_MARK: begin
						state_d = S_SCAN;
					end
					OP_RESUME: begin
						if (sts.list_empty || sts.below_thr) begin
							cmd.set_resp    = 1'b1;
							cmd.resp_status = ST_NONE;
							state_d         = S_RESP;
						end else begin
							state_d = S_RES_LOOP;
						end
					end
					OP_EXPIRE: begin
						if (sts.exp_off) begin
							cmd.set_resp    = 1'b1;
							cmd.resp_status = ST_NONE;
							state_d         = S_RESP;
						end else begin
							state_d = S_EXP_SCAN;
						end
					end
					default: begin
						cmd.set_resp    = 1'b1;
						cmd.resp_status = ST_NONE;
						state_d         = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					cmd.set_resp = 1'b1;
					state_d      = S_RESP;
					if (sts.op != OP_ADD) begin
						cmd.resp_status = ST_NONE;
					end else if (sts.full) begin
						cmd.resp_status = ST_FULL;
					end else begin
						cmd.insert      = 1'b1;
						cmd.resp_status = ST_DONE;
					end
				end else if (sts.hit) begin
					cmd.set_resp = 1'b1;
					state_d      = S_RESP;
					if (sts.op == OP_ADD) begin
						cmd.resp_status = ST_DUP;
					end else if (sts.op == OP_REMOVE) begin
						cmd.drop        = 1'b1;
						cmd.resp_status = ST_DONE;
					end else begin
						cmd.mark        = 1'b1;
						cmd.resp_status = ST_DONE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_RES_LOOP: begin
				if (sts.list_empty) begin
					cmd.set_resp    = 1'b1;
					cmd.resp_status = ST_NONE;
					state_d         = S_RESP;
				end else begin
					cmd.drop = 1'b1;
					if (!sts.head_closing) begin
						cmd.set_resp    = 1'b1;
						cmd.take_conn   = 1'b1;
						cmd.resp_status = ST_DONE;
						state_d         = S_RESP;
					end
				end
			end
			S_EXP_SCAN: begin
				// the previous hit waits in the response register until the next one shows up or the scan ends
				if (sts.scan_end || sts.n_at_cap) begin
					if (sts.n_zero) begin
						cmd.set_resp    = 1'b1;
						cmd.resp_status = ST_NONE;
					end
					state_d = S_RESP;
				end else if (sts.expired) begin
					if (sts.n_zero || sts.out_free) begin
						cmd.emit        = !sts.n_zero;
						cmd.emit_last   = 1'b0;
						cmd.set_resp    = 1'b1;
						cmd.take_conn   = 1'b1;
						cmd.resp_status = ST_DONE;
						cmd.drop        = 1'b1;
						cmd.n_inc       = 1'b1;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/bpwl_dp.sv =====
// Wait list datapath: entry registers, count, scan pointer, config and response register.
// Depends on bpwl_pkg; driven by commands from bpwl_ctrl.
`default_nettype none

module bpwl_dp #(
	parameter int LIST_DEPTH = bpwl_pkg::LIST_DEPTH_DEF,
	parameter int CONN_BITS  = bpwl_pkg::CONN_BITS_DEF,
	parameter int TIME_BITS  = bpwl_pkg::TIME_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [bpwl_pkg::OP_W-1:0]       opcode,
	input  wire  [CONN_BITS-1:0]            conn_id,
	input  wire  [TIME_BITS-1:0]            now_ms,
	input  wire  [bpwl_pkg::BUF_W-1:0]      free_buffers,
	input  wire  [bpwl_pkg::CAP_W-1:0]      expire_cap,
	input  wire                             cfg_valid,
	input  wire  [bpwl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [bpwl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                             rsp_ready,
	output logic                            rsp_valid,
	output logic [bpwl_pkg::STATUS_W-1:0]   status,
	output logic [CONN_BITS-1:0]            result_conn,
	output logic [bpwl_pkg::WAIT_W-1:0]     waiting_after,
	output logic                            last,
	input  bpwl_pkg::cmd_t                  cmd,
	output bpwl_pkg::sts_t                  sts
);
	import bpwl_pkg::*;

	localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int MW_W   = (CNT_W > MAXW_W) ? CNT_W : MAXW_W;
	localparam int CP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int CMP_W  = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

	logic [CONN_BITS-1:0]  conn_q [LIST_DEPTH];
	logic [TIME_BITS-1:0]  time_q [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] closing_q;
	logic [LIST_DEPTH:0]   closing_ext;
	logic [CNT_W-1:0]      count_q;

	logic [MAXW_W-1:0]     max_waiting_q;
	logic [TMO_W-1:0]      wait_timeout_q;
	logic [BUF_W-1:0]      buf_floor_q;

	op_t                   op_q;
	logic [CONN_BITS-1:0]  id_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [BUF_W-1:0]      freeb_q;
	logic [CNT_W-1:0]      cap_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      n_q;

	status_t               resp_status_q;
	logic [CONN_BITS-1:0]  resp_conn_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [CONN_BITS-1:0]  out_conn_q;
	logic [WAIT_W-1:0]     out_wait_q;
	logic                  out_last_q;

	logic [IDX_W-1:0]      rd_idx;
	logic [CONN_BITS-1:0]  rd_conn;
	logic [TIME_BITS-1:0]  rd_time;
	logic [TIME_BITS-1:0]  age;
	logic [MW_W-1:0]       mw_ext;
	logic [MW_W-1:0]       lim;
	logic [CP_W-1:0]       cap_ext;
	logic [CP_W-1:0]       cap_lim;
	logic [BUF_W-1:0]      thr;
	logic                  out_free;
	logic [LIST_DEPTH-1:0] live_mask;

	assign rd_idx      = idx_q[IDX_W-1:0];
	assign rd_conn     = conn_q[rd_idx];
	assign rd_time     = time_q[rd_idx];
	assign age         = now_q - rd_time;
	assign closing_ext = {1'b0, closing_q};

	assign mw_ext  = MW_W'(max_waiting_q);
	assign lim     = (mw_ext > MW_W'(LIST_DEPTH)) ? MW_W'(LIST_DEPTH) : mw_ext;
	assign cap_ext = CP_W'(expire_cap);
	assign cap_lim = (cap_ext > CP_W'(LIST_DEPTH)) ? CP_W'(LIST_DEPTH) : cap_ext;
	assign thr     = (buf_floor_q != '0) ? (buf_floor_q >> 1) : BUF_W'(ZERO_MIN_THR);
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		sts              = '0;
		sts.op           = op_q;
		sts.scan_end     = idx_q >= count_q;
		sts.hit          = rd_conn == id_q;
		sts.full         = MW_W'(count_q) >= lim;
		sts.list_empty   = count_q == '0;
		sts.below_thr    = freeb_q < thr;
		sts.exp_off      = (cap_q == '0) || (wait_timeout_q == '0);
		sts.expired      = (rd_time != '0) && (CMP_W'(age) > CMP_W'(wait_timeout_q));
		sts.n_zero       = n_q == '0;
		sts.n_at_cap     = n_q >= cap_q;
		sts.head_closing = closing_q[0];
		sts.out_free     = out_free;
	end

	// entry payload, no reset: only entries below the count are read
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int j = 1; j < LIST_DEPTH; j++) begin
				conn_q[j] <= conn_q[j-1];
				time_q[j] <= time_q[j-1];
			end
			conn_q[0] <= id_q;
			time_q[0] <= now_q;
		end else if (cmd.drop) begin
			for (int j = 0; j < LIST_DEPTH - 1; j++) begin
				if (CNT_W'(j) >= idx_q) begin
					conn_q[j] <= conn_q[j+1];
					time_q[j] <= time_q[j+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closing_q <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.insert) begin
				closing_q <= {closing_q[LIST_DEPTH-2:0], 1'b0};
				count_q   <= count_q + CNT_W'(1);
			end else if (cmd.drop) begin
				for (int j = 0; j < LIST_DEPTH; j++) begin
					if (CNT_W'(j) >= idx_q) begin
						closing_q[j] <= closing_ext[j+1];
					end
				end
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.mark) begin
				closing_q[rd_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_waiting_q  <= MAX_WAITING_RST;
			wait_timeout_q <= '0;
			buf_floor_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_WAITING:  max_waiting_q  <= cfg_data[MAXW_W-1:0];
				CFG_WAIT_TIMEOUT: wait_timeout_q <= cfg_data[TMO_W-1:0];
				CFG_BUF_FLOOR:    buf_floor_q    <= cfg_data[BUF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			id_q    <= conn_id;
			now_q   <= now_ms;
			freeb_q <= free_buffers;
			cap_q   <= CNT_W'(cap_lim);
		end
		if (cmd.set_resp) begin
			resp_status_q <= cmd.resp_status;
			resp_conn_q   <= cmd.take_conn ? rd_conn : '0;
		end
		if (cmd.emit) begin
			out_status_q <= resp_status_q;
			out_conn_q   <= resp_conn_q;
			out_wait_q   <= WAIT_W'(count_q);
			out_last_q   <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				n_q   <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmd.n_inc) begin
					n_q <= n_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = out_status_q;
	assign result_conn   = out_conn_q;
	assign waiting_after = out_wait_q;
	assign last          = out_last_q;

	always_comb begin
		for (int j = 0; j < LIST_DEPTH; j++) begin
			live_mask[j] = CNT_W'(j) < count_q;
		end
	end

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("response emitted while output register still occupied");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (count_q < CNT_W'(LIST_DEPTH)))
		else $error("insert into a full list");

	a_drop_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> (idx_q < count_q))
		else $error("drop of an entry beyond the count");

	a_closing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(closing_q & ~live_mask) == '0)
		else $error("closing mark set on an unused entry");

endmodule

`default_nettype wire

// ===== rtl/core/backpressure_wait_list_top.sv =====
// Backpressure wait list: a bounded newest-first list of stalled connections with resume,
// expiry, remove and mark-closing. Instantiates bpwl_ctrl and bpwl_dp; uses bpwl_pkg and
// the channel interfaces in bpwl_intf.
//
// One request is handled at a time and gives one response; an expire request gives one per
// expired entry, or one ST_NONE response when none expired (last marks the final one). The
// list sits in registers and is walked one entry per cycle, except while an expired entry
// waits for the response side. Add, remove and mark closing compare entries until a match or
// the end of the list; resume gives ST_NONE when the list is empty or the pool is below
// threshold, else drops closing heads until a live head is returned or the list runs out;
// expire gives ST_NONE when disabled or capped at zero, else examines entries until the cap
// or the end of the list. The next request is taken in the cycle after the final response is
// loaded. Configuration writes are always taken and must only be issued while idle.
`default_nettype none

module backpressure_wait_list_top #(
	parameter int LIST_DEPTH = bpwl_pkg::LIST_DEPTH_DEF,
	parameter int CONN_BITS  = bpwl_pkg::CONN_BITS_DEF,
	parameter int TIME_BITS  = bpwl_pkg::TIME_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	bpwl_req_if.sink    req,
	bpwl_rsp_if.source  rsp,
	bpwl_cfg_if.sink    cfg
);
	import bpwl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	bpwl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpwl_dp #(
		.LIST_DEPTH (LIST_DEPTH),
		.CONN_BITS  (CONN_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (req.opcode),
		.conn_id       (req.conn_id),
		.now_ms        (req.now_ms),
		.free_buffers  (req.free_buffers),
		.expire_cap    (req.expire_cap),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.status        (rsp.status),
		.result_conn   (rsp.result_conn),
		.waiting_after (rsp.waiting_after),
		.last          (rsp.last),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire

// ===== tb/bpwl_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the backpressure wait list: watches the request, response and
// configuration channels, keeps its own copy of the list and compares responses in order.
// Depends on bpwl_pkg and the channel interfaces in bpwl_intf.
module bpwl_checker #(
	parameter int LIST_DEPTH = bpwl_pkg::LIST_DEPTH_DEF,
	parameter int CONN_BITS  = bpwl_pkg::CONN_BITS_DEF,
	parameter int TIME_BITS  = bpwl_pkg::TIME_BITS_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	bpwl_req_if   req,
	bpwl_rsp_if   rsp,
	bpwl_cfg_if   cfg,
	output int    failures,
	output int    pending,
	output int    responses
);
	import bpwl_pkg::*;

	typedef logic [CONN_BITS-1:0] conn_t;
	typedef logic [TIME_BITS-1:0] stamp_t;

	typedef struct packed {
		status_t           status;
		conn_t             conn;
		logic [WAIT_W-1:0] waiting;
		logic              last;
	} wl_rsp_t;

	conn_t             list_conn    [LIST_DEPTH];
	stamp_t            list_time    [LIST_DEPTH];
	bit                list_closing [LIST_DEPTH];
	int                list_len;
	logic [MAXW_W-1:0] max_waiting;
	logic [TMO_W-1:0]  wait_timeout;
	logic [BUF_W-1:0]  buf_floor;
	wl_rsp_t           expected_rsp [$];
	int                fail_count;
	int                rsp_count;

	function automatic int find_conn(conn_t c);
		for (int i = 0; i < list_len; i++)
			if (list_conn[i] == c)
				return i;
		return -1;
	endfunction

	function automatic void drop_entry(int p);
		for (int i = p; i + 1 < list_len; i++) begin
			list_conn[i]    = list_conn[i + 1];
			list_time[i]    = list_time[i + 1];
			list_closing[i] = list_closing[i + 1];
		end
		list_len--;
		list_closing[list_len] = 1'b0;
	endfunction

	function automatic void expect_rsp(status_t st, conn_t c, logic fin);
		wl_rsp_t r;
		r.status  = st;
		r.conn    = c;
		r.waiting = WAIT_W'(list_len);
		r.last    = fin;
		expected_rsp.push_back(r);
	endfunction

	function automatic void predict_request(op_t op, conn_t c, stamp_t now,
		logic [BUF_W-1:0] freeb, logic [CAP_W-1:0] cap);
		int               p;
		int               lim;
		int               n;
		int               i;
		int               cap_n;
		logic [BUF_W-1:0] thr;
		conn_t            got;
		bit               cl;
		bit               done;
		wl_rsp_t          r;
		case (op)
			OP_ADD: begin
				lim = (max_waiting > LIST_DEPTH) ? LIST_DEPTH : int'(max_waiting);
				if (find_conn(c) >= 0) begin
					expect_rsp(ST_DUP, '0, 1'b1);
				end else if (list_len >= lim) begin
					expect_rsp(ST_FULL, '0, 1'b1);
				end else begin
					for (i = list_len; i > 0; i--) begin
						list_conn[i]    = list_conn[i - 1];
						list_time[i]    = list_time[i - 1];
						list_closing[i] = list_closing[i - 1];
					end
					list_conn[0]    = c;
					list_time[0]    = now;
					list_closing[0] = 1'b0;
					list_len++;
					expect_rsp(ST_DONE, '0, 1'b1);
				end
			end
			OP_REMOVE, OP_MARK: begin
				p = find_conn(c);
				if (p < 0) begin
					expect_rsp(ST_NONE, '0, 1'b1);
				end else begin
					if (op == OP_REMOVE)
						drop_entry(p);
					else
						list_closing[p] = 1'b1;
					expect_rsp(ST_DONE, '0, 1'b1);
				end
			end
			OP_RESUME: begin
				thr = (buf_floor != 0) ? (buf_floor >> 1) : BUF_W'(ZERO_MIN_THR);
				if (list_len == 0 || freeb < thr) begin
					expect_rsp(ST_NONE, '0, 1'b1);
				end else begin
					done = 1'b0;
					while (list_len > 0 && !done) begin
						cl  = list_closing[0];
						got = list_conn[0];
						drop_entry(0);
						if (!cl) begin
							expect_rsp(ST_DONE, got, 1'b1);
							done = 1'b1;
						end
					end
					if (!done)
						expect_rsp(ST_NONE, '0, 1'b1);
				end
			end
			OP_EXPIRE: begin
				n     = 0;
				cap_n = (cap > LIST_DEPTH) ? LIST_DEPTH : int'(cap);
				if (cap_n != 0 && wait_timeout != 0) begin
					i = 0;
					while (i < list_len && n < cap_n) begin
						if (list_time[i] != 0 &&
							stamp_t'(now - list_time[i]) > stamp_t'(wait_timeout)) begin
							got = list_conn[i];
							drop_entry(i);
							expect_rsp(ST_DONE, got, 1'b0);
							n++;
						end else begin
							i++;
						end
					end
				end
				if (n == 0) begin
					expect_rsp(ST_NONE, '0, 1'b1);
				end else begin
					r = expected_rsp.pop_back();
					r.last = 1'b1;
					expected_rsp.push_back(r);
				end
			end
			default: begin
				expect_rsp(ST_NONE, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		wl_rsp_t want;
		if (!arst_n) begin
			list_len     = 0;
			max_waiting  = MAX_WAITING_RST;
			wait_timeout = '0;
			buf_floor    = '0;
			foreach (list_closing[i])
				list_closing[i] = 1'b0;
			expected_rsp.delete();
			fail_count   = 0;
			rsp_count    = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_MAX_WAITING:  max_waiting  = cfg.data[MAXW_W-1:0];
					CFG_WAIT_TIMEOUT: wait_timeout = cfg.data[TMO_W-1:0];
					CFG_BUF_FLOOR:    buf_floor    = cfg.data[BUF_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				predict_request(req.opcode, req.conn_id, req.now_ms, req.free_buffers,
					req.expire_cap);
			if (rsp.valid && rsp.ready) begin
				rsp_count++;
				if (expected_rsp.size() == 0) begin
					$error("response with nothing outstanding: status %0d conn %0h",
						rsp.status, rsp.result_conn);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("status", 64'(want.status), 64'(rsp.status));
					check_field("result_conn", 64'(want.conn), 64'(rsp.result_conn));
					check_field("waiting_after", 64'(want.waiting), 64'(rsp.waiting_after));
					check_field("last", 64'(want.last), 64'(rsp.last));
				end
			end
		end
		failures  <= fail_count;
		pending   <= expected_rsp.size();
		responses <= rsp_count;
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the wait list testbench: makes requests, register writes and response stalls for
// backpressure_wait_list_top and reports the verdict from bpwl_checker.
// Depends on bpwl_pkg, bpwl_intf and bpwl_checker.
module testbench;
	import bpwl_pkg::*;

	typedef logic [CONN_BITS_DEF-1:0] conn_t;
	typedef logic [TIME_BITS_DEF-1:0] stamp_t;

	localparam op_t    OP_BAD_LO    = 3'd5;
	localparam op_t    OP_BAD_HI    = '1;
	localparam int     DRAIN_CYCLES = 2 * LIST_DEPTH_DEF + 8;
	localparam int     POOL_SIZE    = 24;
	localparam stamp_t TIME_TOP     = '1;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	int     failures;
	int     pending;
	int     responses;
	int     n_sent;
	int     n_settings;
	int     op_count [8];
	bit     steady;
	stamp_t clock_ms;
	conn_t  id_pool [POOL_SIZE];

	bpwl_req_if req ();
	bpwl_rsp_if rsp ();
	bpwl_cfg_if cfg ();

	backpressure_wait_list_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	bpwl_checker CHECK (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.failures  (failures),
		.pending   (pending),
		.responses (responses)
	);

	always #5 clk = ~clk;

	initial begin
		#8_000_000;
		$display("Run stopped by time limit, %0d responses outstanding", pending);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(op_t op, conn_t c, stamp_t now, logic [BUF_W-1:0] freeb,
		logic [CAP_W-1:0] cap);
		int gap;
		gap = steady ? 0 : gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.conn_id      <= c;
		req.now_ms       <= now;
		req.free_buffers <= freeb;
		req.expire_cap   <= cap;
		do @(posedge clk); while (!req.ready);
		n_sent++;
		op_count[op]++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] maxw, logic [CFG_DATA_W-1:0] tmo,
		logic [CFG_DATA_W-1:0] minb);
		write_reg(CFG_MAX_WAITING, maxw);
		write_reg(CFG_WAIT_TIMEOUT, tmo);
		write_reg(CFG_BUF_FLOOR, minb);
		cfg.valid <= 1'b0;
		n_settings++;
	endtask

	// response side stalls
	initial begin
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = gap_len();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(40, 120)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		int               r;
		int               others;
		op_t              op;
		conn_t            c;
		stamp_t           now;
		stamp_t           t0;
		logic [BUF_W-1:0] freeb;
		req.valid        <= 1'b0;
		req.opcode       <= OP_ADD;
		req.conn_id      <= '0;
		req.now_ms       <= '0;
		req.free_buffers <= '0;
		req.expire_cap   <= '0;
		cfg.valid        <= 1'b0;
		cfg.index        <= CFG_MAX_WAITING;
		cfg.data         <= '0;
		steady     = 1'b0;
		n_sent     = 0;
		n_settings = 1;
		foreach (op_count[i])
			op_count[i] = 0;
		foreach (id_pool[i])
			id_pool[i] = conn_t'($urandom);
		id_pool[0] = '0;
		id_pool[1] = '1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no expiry, resume threshold 2
		send_request(OP_RESUME, 16'h1234, '0, '1, 5'd16);
		send_request(OP_EXPIRE, 16'h1234, TIME_TOP, '0, 5'd16);
		send_request(OP_ADD, 16'h0000, '0, '0, '0);
		send_request(OP_ADD, 16'hFFFF, TIME_TOP, '1, '1);
		send_request(OP_ADD, 16'hFFFF, 48'd77, '0, '0);
		send_request(OP_REMOVE, 16'h1234, '0, '0, '0);
		send_request(OP_MARK, 16'h1234, '0, '0, '0);
		send_request(OP_MARK, 16'hFFFF, '0, '0, '0);
		send_request(OP_RESUME, '0, '0, 32'd1, '0);
		send_request(OP_RESUME, '0, '0, 32'd2, '0);
		send_request(OP_RESUME, '0, '0, '1, '0);
		send_request(OP_BAD_LO, 16'hFFFF, TIME_TOP, '1, '1);
		send_request(OP_BAD_HI, '0, '0, '0, '0);
		send_request(OP_ADD, 16'h00AA, 48'd9, '0, '0);
		send_request(OP_MARK, 16'h00AA, '0, '0, '0);
		send_request(OP_RESUME, '0, '0, '1, '0);
		drain();

		// three entries, timeout 100, threshold 4
		set_config(32'd3, 32'd100, 32'd9);
		t0 = 48'h0000_1000_0000;
		send_request(OP_ADD, 16'h0101, t0, '0, '0);
		send_request(OP_ADD, 16'h0202, t0 + 10, '0, '0);
		send_request(OP_ADD, 16'h0303, t0 + 20, '0, '0);
		send_request(OP_ADD, 16'h0404, t0 + 30, '0, '0);
		send_request(OP_EXPIRE, '0, t0 + 1000, '0, 5'd0);
		send_request(OP_EXPIRE, '0, t0 + 50, '0, 5'd31);
		send_request(OP_EXPIRE, '0, t0 + 115, '0, 5'd2);
		send_request(OP_REMOVE, 16'h0303, '0, '0, '0);
		send_request(OP_ADD, 16'h0505, '0, '0, '0);
		send_request(OP_ADD, 16'h0606, TIME_TOP - 9, '0, '0);
		send_request(OP_EXPIRE, '0, 48'd5, '0, 5'd31);
		send_request(OP_EXPIRE, '0, 48'd200, '0, 5'd31);
		send_request(OP_RESUME, '0, '0, 32'd3, '0);
		send_request(OP_RESUME, '0, '0, 32'd4, '0);
		drain();

		set_config(32'd0, 32'd0, 32'd0);
		send_request(OP_ADD, 16'h5A5A, 48'd1, '0, '0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_config(32'd16, '1, '1);
					clock_ms = {16'($urandom), 32'($urandom)};
				end
				1: begin
					set_config(32'd31, 32'd200, 32'd1);
					clock_ms = TIME_TOP - 3000;
				end
				default: begin
					set_config($urandom_range(1, 16), $urandom_range(20, 400),
						$urandom_range(0, 40));
					clock_ms = stamp_t'($urandom);
				end
			endcase
			for (int k = 0; k < 50; k++) begin
				if (k % 25 == 0)
					steady = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 35)
					op = OP_ADD;
				else if (r < 47)
					op = OP_REMOVE;
				else if (r < 65)
					op = OP_RESUME;
				else if (r < 85)
					op = OP_EXPIRE;
				else if (r < 95)
					op = OP_MARK;
				else
					op = op_t'($urandom_range(int'(OP_BAD_LO), int'(OP_BAD_HI)));
				c = ($urandom_range(0, 9) == 0) ? conn_t'($urandom) :
					id_pool[$urandom_range(0, POOL_SIZE - 1)];
				clock_ms += stamp_t'($urandom_range(0, 40));
				now = ($urandom_range(0, 19) == 0) ?
					{16'($urandom), 32'($urandom)} : clock_ms;
				freeb = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
					32'($urandom_range(0, 40));
				send_request(op, c, now, freeb, CAP_W'($urandom));
			end
			steady = 1'b0;
			drain();
		end

		others = n_sent - op_count[OP_ADD] - op_count[OP_REMOVE] - op_count[OP_RESUME]
			- op_count[OP_EXPIRE] - op_count[OP_MARK];
		$display("Requests: %0d (add %0d, remove %0d, resume %0d, expire %0d, mark %0d, other %0d)",
			n_sent, op_count[OP_ADD], op_count[OP_REMOVE], op_count[OP_RESUME],
			op_count[OP_EXPIRE], op_count[OP_MARK], others);
		$display("Responses checked: %0d across %0d register settings", responses, n_settings);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bpwl_pkg.sv
rtl/core/bpwl_intf.sv
rtl/core/bpwl_ctrl.sv
rtl/core/bpwl_dp.sv
rtl/core/backpressure_wait_list_top.sv
tb/bpwl_checker.sv
tb/testbench.sv
